### src/mlp_pkg.sv
`timescale 1ns / 1ps

package mlp_pkg;

    localparam logic [6:0] LETTER_A = 7'd65;
    localparam logic [6:0] LETTER_Z = 7'd90;

    localparam int MAX_SYMS = 5;

    typedef logic [1:0] symbol_t;

    localparam symbol_t SYM_DOT  = 2'b00;
    localparam symbol_t SYM_DASH = 2'b01;
    localparam symbol_t SYM_GAP  = 2'b10;
    localparam symbol_t SYM_END  = 2'b11;

    function automatic logic [2:0] pat_len(input logic [4:0] k);
        logic [2:0] len;
        case (k)
            5'd0:    len = 3'd2;
            5'd1:    len = 3'd4;
            5'd2:    len = 3'd4;
            5'd3:    len = 3'd3;
            5'd4:    len = 3'd1;
            5'd5:    len = 3'd4;
            5'd6:    len = 3'd3;
            5'd7:    len = 3'd4;
            5'd8:    len = 3'd2;
            5'd9:    len = 3'd4;
            5'd10:   len = 3'd3;
            5'd11:   len = 3'd4;
            5'd12:   len = 3'd2;
            5'd13:   len = 3'd2;
            5'd14:   len = 3'd3;
            5'd15:   len = 3'd4;
            5'd16:   len = 3'd4;
            5'd17:   len = 3'd3;
            5'd18:   len = 3'd3;
            5'd19:   len = 3'd1;
            5'd20:   len = 3'd3;
            5'd21:   len = 3'd4;
            5'd22:   len = 3'd3;
            5'd23:   len = 3'd4;
            5'd24:   len = 3'd4;
            5'd25:   len = 3'd4;
            default: len = 3'd0;
        endcase
        return len;
    endfunction

    // dash = 1, dot = 0, first symbol in the highest used bit
    function automatic logic [3:0] pat_bits(input logic [4:0] k);
        logic [3:0] bits;
        case (k)
            5'd0:    bits = 4'h1;
            5'd1:    bits = 4'h8;
            5'd2:    bits = 4'hA;
            5'd3:    bits = 4'h4;
            5'd4:    bits = 4'h0;
            5'd5:    bits = 4'h2;
            5'd6:    bits = 4'h6;
            5'd7:    bits = 4'h0;
            5'd8:    bits = 4'h0;
            5'd9:    bits = 4'h7;
            5'd10:   bits = 4'h5;
            5'd11:   bits = 4'h4;
            5'd12:   bits = 4'h3;
            5'd13:   bits = 4'h2;
            5'd14:   bits = 4'h7;
            5'd15:   bits = 4'h6;
            5'd16:   bits = 4'hD;
            5'd17:   bits = 4'h2;
            5'd18:   bits = 4'h0;
            5'd19:   bits = 4'h1;
            5'd20:   bits = 4'h1;
            5'd21:   bits = 4'h1;
            5'd22:   bits = 4'h3;
            5'd23:   bits = 4'h9;
            5'd24:   bits = 4'hB;
            5'd25:   bits = 4'hC;
            default: bits = 4'h0;
        endcase
        return bits;
    endfunction

endpackage

### src/morse_letter_packer.sv
// A completed word is queued when its letter is accepted and leaves on packed_word from the queue
// head. Throughput: one letter per cycle; a letter may finish up to two words, which drain one
// per cycle while word_stall is low via a four-word queue; letter_stall is high at three or more.
// Reset (rst_n low, asynchronous) empties the queue and clears the open word and its count.
`timescale 1ns / 1ps

module morse_letter_packer #(
    parameter int WORD_BITS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        letter_valid,
    output logic        letter_stall,
    input  logic [6:0]  letter,
    input  logic        final_letter,
    output logic        word_valid,
    input  logic        word_stall,
    output logic [63:0] packed_word,
    output logic        last_word
);
    import mlp_pkg::*;

    localparam int SYMS  = WORD_BITS / 2;
    localparam int CW    = $clog2(SYMS + 1);
    localparam int SW    = $clog2(WORD_BITS + 1);
    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);
    localparam int QCW   = $clog2(DEPTH + 1);

    typedef struct packed {
        logic [WORD_BITS-1:0] data;
        logic                 last;
    } entry_t;

    logic [WORD_BITS-1:0] acc_reg, acc_next;
    logic [CW-1:0]        fill_reg, fill_next;

    entry_t               q_reg [DEPTH];
    logic [PW-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [PW-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [QCW-1:0]       count_reg, count_next;

    logic                 accept;
    logic                 pop;
    logic                 in_range;
    logic [4:0]           idx;
    logic [2:0]           len;
    logic [3:0]           bits;
    logic [2:0]           nsym;
    logic [2:0]           bit_pos;
    symbol_t              sym;
    logic [WORD_BITS-1:0] acc_w;
    logic [CW-1:0]        fill_w;
    logic [1:0]           nres;
    entry_t               res0, res1;
    logic [SW-1:0]        pad_sh;
    logic [WORD_BITS-1:0] pad_word;

    assign accept       = letter_valid && !letter_stall;
    assign letter_stall = (count_reg > QCW'(DEPTH - 2));
    assign word_valid   = (count_reg != '0);
    assign pop          = word_valid && !word_stall;
    assign packed_word  = 64'(q_reg[rd_ptr_reg].data);
    assign last_word    = q_reg[rd_ptr_reg].last;

    always_comb
    begin
        in_range = letter inside {[LETTER_A:LETTER_Z]};
        idx      = 5'(letter - LETTER_A);
        len      = pat_len(idx);
        bits     = pat_bits(idx);
        if (!in_range)
            nsym = 3'd0;
        else if (final_letter)
            nsym = len;
        else
            nsym = len + 3'd1;

        acc_w   = acc_reg;
        fill_w  = fill_reg;
        nres    = 2'd0;
        res0    = '0;
        res1    = '0;
        bit_pos = 3'd0;
        sym     = SYM_DOT;
        for (int i = 0; i < MAX_SYMS; i++)
        begin
            bit_pos = len - 3'(i) - 3'd1;
            if (3'(i) < len)
                sym = bits[bit_pos[1:0]] ? SYM_DASH : SYM_DOT;
            else
                sym = SYM_GAP;
            if (3'(i) < nsym)
            begin
                acc_w  = (acc_w << 2) | WORD_BITS'(sym);
                fill_w = fill_w + CW'(1);
                if (fill_w == CW'(SYMS))
                begin
                    if (nres == 2'd0)
                        res0 = '{data: acc_w, last: 1'b0};
                    else
                        res1 = '{data: acc_w, last: 1'b0};
                    nres   = nres + 2'd1;
                    acc_w  = '0;
                    fill_w = '0;
                end
            end
        end

        // pad the open word with end symbols; an empty word becomes all ones
        pad_sh   = SW'(2 * (SYMS - int'(fill_w)));
        pad_word = (acc_w << pad_sh) | ~({WORD_BITS{1'b1}} << pad_sh);
        if (final_letter)
        begin
            if (nres == 2'd0)
                res0 = '{data: pad_word, last: 1'b1};
            else
                res1 = '{data: pad_word, last: 1'b1};
            nres   = nres + 2'd1;
            acc_w  = '0;
            fill_w = '0;
        end

        acc_next    = accept ? acc_w : acc_reg;
        fill_next   = accept ? fill_w : fill_reg;
        wr_ptr_next = accept ? wr_ptr_reg + PW'(nres) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PW'(1) : rd_ptr_reg;
        count_next  = count_reg + (accept ? QCW'(nres) : QCW'(0)) - (pop ? QCW'(1) : QCW'(0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg    <= '0;
            fill_reg   <= '0;
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            acc_reg    <= acc_next;
            fill_reg   <= fill_next;
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && nres != 2'd0)
            q_reg[wr_ptr_reg] <= res0;
        if (accept && nres == 2'd2)
            q_reg[wr_ptr_reg + PW'(1)] <= res1;
    end

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCW'(DEPTH))
        else $error("output queue overflow");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg < CW'(SYMS))
        else $error("open word count out of range");

    a_empty_acc: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg == '0 |-> acc_reg == '0)
        else $error("empty open word holds symbols");

    a_final_closes: assert property (@(posedge clk) disable iff (!rst_n)
        accept && final_letter |=> fill_reg == '0 && count_reg != '0)
        else $error("final letter left the word open");

endmodule
